### rtl/core/button_edge_event_fifo_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button edge event queue
// Concurrent checks are compiled for simulation only and vanish in synthesis.
// ----------------------------------------------------------------------------
// Each check is sampled on clk_i. The first macro is held off while rst_ni is
// low; the second is also evaluated during reset.
`ifndef BUTTON_EDGE_EVENT_FIFO_DEFINES_SVH
`define BUTTON_EDGE_EVENT_FIFO_DEFINES_SVH

`ifndef SYNTHESIS
`define BEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BEF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BEF_ASSERT(lbl, prop, msg)
`define BEF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/bef_pkg.sv
// ----------------------------------------------------------------------------
// Button edge event package
// Command and event codes, the controller command bundle and the edge decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bef_pkg;

  // Bit positions in a button sample.
  localparam int unsigned BtnDown   = 0;
  localparam int unsigned BtnRight  = 1;
  localparam int unsigned BtnUp     = 2;
  localparam int unsigned BtnCenter = 3;
  localparam int unsigned BtnLeft   = 4;

  localparam int unsigned BtnW  = 5;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned EvW   = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_READ   = 2'd1,
    CMD_INIT   = 2'd2
  } cmd_e;

  typedef enum logic [EvW-1:0] {
    EV_NONE   = 3'd0,
    EV_CPRESS = 3'd1,
    EV_CREL   = 3'd2,
    EV_UP     = 3'd3,
    EV_DOWN   = 3'd4,
    EV_LEFT   = 3'd5,
    EV_RIGHT  = 3'd6
  } ev_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming command and sample
    logic exec;  // carry out the captured command and present the result
  } bef_cmd_t;

  // Turns the change between two samples into at most one event. The centre
  // button reports both edges; the directions report presses only.
  function automatic ev_e decode_change(logic [BtnW-1:0] prev, logic [BtnW-1:0] curr);
    logic [BtnW-1:0] diff;
    logic [BtnW-1:0] rose;
    ev_e             ev;
    diff = prev ^ curr;
    rose = diff & curr;
    priority if (diff[BtnCenter]) begin
      ev = curr[BtnCenter] ? EV_CPRESS : EV_CREL;
    end else if (rose[BtnUp]) begin
      ev = EV_UP;
    end else if (rose[BtnDown]) begin
      ev = EV_DOWN;
    end else if (rose[BtnLeft]) begin
      ev = EV_LEFT;
    end else if (rose[BtnRight]) begin
      ev = EV_RIGHT;
    end else begin
      ev = EV_NONE;
    end
    return ev;
  endfunction

endpackage

### rtl/core/button_edge_event_fifo.sv
// ----------------------------------------------------------------------------
// Button edge event queue
// Decodes joystick sample edges into events and queues them for reading.
// ----------------------------------------------------------------------------
// Usage. A command transfer happens on the rising edge at which start is high
// and busy is low; command_i selects a new sample, a read of the oldest event
// or an initialisation, and buttons_i carries the sample. Each command yields
// exactly one result, shown on event_code_o, dropped_o and has_event_o for a
// single cycle while strobe_o is high; that cycle's closing edge is the result
// transfer. The receiver cannot stall, so it must capture the result then.
// A command passes ST_READ, ST_EXEC and the strobe register before its strobe.
// busy is high in ST_READ and ST_EXEC, in which no new command is taken: first
// the queue head is read from the event store through its registered read port,
// then the edge is decoded and the pointers are updated. A new command may be
// transferred in the cycle the previous result is shown.
// The queue keeps QUEUE_DEPTH-1 events; one slot stays free so that equal
// pointers mean empty. A decoded event that meets a full queue is discarded
// and flagged by dropped_o.
// Reset clears the previous sample and both pointers, leaving the queue empty.
// The event store itself is not cleared; only entries already written are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_edge_event_fifo #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [bef_pkg::CmdW-1:0] command_i,
  input  logic [bef_pkg::BtnW-1:0] buttons_i,
  output logic                     strobe_o,
  output logic [bef_pkg::EvW-1:0]  event_code_o,
  output logic                     dropped_o,
  output logic                     has_event_o
);
  import bef_pkg::*;

  // Command bundle from the sequencer to the datapath.
  bef_cmd_t cmd;

  // The controller only sequences; it never sees the payload.
  bef_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // The datapath holds all state that the commands act on, including the
  // event store, and registers every result field before it is shown.
  bef_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .command_i    (command_i),
    .buttons_i    (buttons_i),
    .strobe_o     (strobe_o),
    .event_code_o (event_code_o),
    .dropped_o    (dropped_o),
    .has_event_o  (has_event_o)
  );

endmodule

### rtl/core/bef_ctrl.sv
// ----------------------------------------------------------------------------
// Button edge event controller
// Sequences one command through fetch of the queue head and execution.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bef_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output bef_pkg::bef_cmd_t cmd_o
);
  import bef_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The queue head is read while in ST_READ, so it is stable in ST_EXEC.
  assign busy       = (state_q != ST_IDLE);
  assign cmd_o.load = (state_q == ST_IDLE) && start;
  assign cmd_o.exec = (state_q == ST_EXEC);

endmodule

### rtl/core/bef_dp.sv
// ----------------------------------------------------------------------------
// Button edge event datapath
// Holds the previous sample, the circular event queue and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "button_edge_event_fifo_defines.svh"

module bef_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bef_pkg::bef_cmd_t            cmd_i,
  input  logic [bef_pkg::CmdW-1:0]     command_i,
  input  logic [bef_pkg::BtnW-1:0]     buttons_i,
  output logic                         strobe_o,
  output logic [bef_pkg::EvW-1:0]      event_code_o,
  output logic                         dropped_o,
  output logic                         has_event_o
);
  import bef_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  logic [CmdW-1:0] cmd_q;
  logic [BtnW-1:0] btn_q;
  logic [BtnW-1:0] prev_q, prev_d;
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [EvW-1:0]  mem_q [QUEUE_DEPTH];
  logic [EvW-1:0]  head_q;
  logic            strobe_q;
  logic [EvW-1:0]  code_q, code_d;
  logic            drop_q, drop_d;
  logic            has_q;

  ev_e             ev;
  logic [PtrW-1:0] wr_next;
  logic [PtrW-1:0] rd_next;
  logic            mem_we;
  logic            read_empty;

  assign ev      = decode_change(prev_q, btn_q);
  assign wr_next = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
  assign rd_next = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;

  always_comb begin
    prev_d = prev_q;
    wr_d   = wr_q;
    rd_d   = rd_q;
    code_d = EV_NONE;
    drop_d = 1'b0;
    mem_we = 1'b0;
    unique case (cmd_q)
      CMD_SAMPLE: begin
        prev_d = btn_q;
        if (ev != EV_NONE) begin
          if (wr_next == rd_q) begin
            drop_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            wr_d   = wr_next;
          end
        end
      end
      CMD_READ: begin
        if (wr_q != rd_q) begin
          code_d = head_q;
          rd_d   = rd_next;
        end
      end
      CMD_INIT: begin
        prev_d = btn_q;
        wr_d   = '0;
        rd_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.exec;
      if (cmd_i.exec) begin
        prev_q <= prev_d;
        wr_q   <= wr_d;
        rd_q   <= rd_d;
      end
    end
  end

  // Captured command and result registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      btn_q <= buttons_i;
    end
    if (cmd_i.exec) begin
      code_q <= code_d;
      drop_q <= drop_d;
      has_q  <= (wr_d != rd_d);
    end
  end

  // Event store: one write port at the write pointer, one registered read
  // port at the read pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem_q[wr_q] <= ev;
    end
    head_q <= mem_q[rd_q];
  end

  assign strobe_o     = strobe_q;
  assign event_code_o = code_q;
  assign dropped_o    = drop_q;
  assign has_event_o  = has_q;

  assign read_empty = cmd_i.exec && (cmd_q == CMD_READ) && (wr_q == rd_q);

  `BEF_ASSERT(a_strobe_follows_exec, cmd_i.exec |=> strobe_q, "result strobe missing")
  `BEF_ASSERT(a_drop_no_code, strobe_q && drop_q |-> code_q == EV_NONE, "drop with a code")
  `BEF_ASSERT(a_empty_read_none, read_empty |=> code_q == EV_NONE && !has_q, "empty read gave an event")
  `BEF_ASSERT(a_ptr_range, wr_q <= PtrLast && rd_q <= PtrLast, "queue pointer out of range")

endmodule
